>>> sv/lcdq_pkg.sv
// ----------------------------------------------------------------------------
// lcdq_pkg
// Types, register codes and byte helpers for the LCD command queue serializer.
// ----------------------------------------------------------------------------
package lcdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_ON  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RS_POS        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_POS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_POS = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DB4_POS       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DB5_POS       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DB6_POS       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DB7_POS       = 4'd7;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  typedef logic [2:0] pos_t;

  typedef struct packed {
    logic       req_type;
    logic       cmd_is_data;
    logic       cmd_nibble_mode;
    logic [7:0] cmd_data;
    logic [5:0] cmd_delay;
    logic       link_idle;
  } req_t;

  typedef struct packed {
    logic       res_kind;
    logic       push_accepted;
    logic [7:0] bus_byte;
    logic       last_byte;
  } res_t;

  typedef struct packed {
    logic       is_data;
    logic       nibble;
    logic [7:0] data;
    logic [5:0] delay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [7:0] line_mask(input pos_t pos);
    return 8'd1 << pos;
  endfunction

  // D4..D7 onto their expander lines
  function automatic logic [7:0] place_nibble(input logic [3:0] nib,
                                              input pos_t [3:0] db_pos);
    logic [7:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (nib[k]) v = v | line_mask(db_pos[k]);
    end
    return v;
  endfunction

endpackage

>>> sv/lcdq_stream_if.sv
// ----------------------------------------------------------------------------
// lcdq_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface lcdq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/char_lcd_command_queue_serializer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_command_queue_serializer_top
// Queues character-LCD commands in a ring RAM and plays each one out as
// expander bytes that strobe E while placing RS, backlight and data lines.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | carries
//  request  | in  | valid/ready   | push (command) or tick
//  result   | out | valid/ready   | push status or one expander byte
//  cfg      | in  | cfg_we        | register index and write data
//
// A push writes its status into the output register. A tick that pops issues
// the RAM read, loads the entry in READ, then emits one byte per cycle while
// the result is not stalled: 4 bytes for a nibble command, 7 for a byte one.
// Other ticks only count down a nonzero wait counter. Reset empties the ring;
// RAM contents persist. Result stalls hold the byte loop; a request is taken
// only in the idle state with the output register free or being drained.
module char_lcd_command_queue_serializer_top #(
  parameter int QUEUE_DEPTH = lcdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  lcdq_stream_if.sink                          request,
  lcdq_stream_if.source                        result,
  input  logic                                 cfg_we,
  input  logic [lcdq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcdq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam int ENTRY_W_L = lcdq_pkg::ENTRY_W;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

  state_t                   state;
  logic [IDX_W-1:0]         write_index;
  logic [IDX_W-1:0]         read_index;
  logic [5:0]               wait_counter;
  logic                     backlight_on;
  lcdq_pkg::pos_t           rs_pos;
  lcdq_pkg::pos_t           en_pos;
  lcdq_pkg::pos_t           bl_pos;
  lcdq_pkg::pos_t [3:0]     db_pos;
  lcdq_pkg::entry_t         cur_entry;
  logic [7:0]               cur_byte;
  logic [2:0]               step;
  logic                     res_valid;
  lcdq_pkg::res_t           res_data;

  lcdq_pkg::req_t           req;
  lcdq_pkg::entry_t         push_entry;
  lcdq_pkg::entry_t         rd_entry;
  logic [ENTRY_W_L-1:0]     rd_raw;
  logic                     out_free;
  logic                     req_fire;
  logic                     is_push;
  logic                     is_tick;
  logic                     ring_full;
  logic                     ring_empty;
  logic                     do_pop;
  logic                     res_load;
  logic [IDX_W-1:0]         write_index_next;
  logic [IDX_W-1:0]         read_index_next;
  logic [7:0]               e_mask;
  logic [7:0]               db_mask;
  logic [3:0]               hi_nib;
  logic [7:0]               first_byte;
  logic [7:0]               cur_byte_next;
  logic                     last_step;

  assign req      = request.payload;
  assign out_free = !res_valid || result.ready;
  assign request.ready = (state == ST_IDLE) && out_free;
  assign req_fire = request.valid && request.ready;
  assign is_push  = req_fire && (req.req_type == lcdq_pkg::REQ_PUSH);
  assign is_tick  = req_fire && (req.req_type == lcdq_pkg::REQ_TICK);
  assign res_load = is_push || ((state == ST_EMIT) && out_free);

  assign write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
  assign read_index_next  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
  assign ring_full  = (write_index_next == read_index);
  assign ring_empty = (write_index == read_index);
  assign do_pop = is_tick && (wait_counter == '0) && req.link_idle && !ring_empty;

  assign push_entry.is_data = req.cmd_is_data;
  assign push_entry.nibble  = req.cmd_nibble_mode;
  assign push_entry.data    = req.cmd_data;
  assign push_entry.delay   = req.cmd_delay;

  lcdq_ram #(
    .WIDTH (ENTRY_W_L),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (is_push && !ring_full),
    .waddr (write_index),
    .wdata (push_entry),
    .re    (do_pop),
    .raddr (read_index),
    .rdata (rd_raw)
  );

  assign rd_entry = lcdq_pkg::entry_t'(rd_raw);

  assign e_mask  = lcdq_pkg::line_mask(en_pos);
  assign db_mask = lcdq_pkg::line_mask(db_pos[0]) | lcdq_pkg::line_mask(db_pos[1]) |
                   lcdq_pkg::line_mask(db_pos[2]) | lcdq_pkg::line_mask(db_pos[3]);
  assign first_byte = (rd_entry.is_data ? lcdq_pkg::line_mask(rs_pos) : 8'd0) |
                      (backlight_on ? lcdq_pkg::line_mask(bl_pos) : 8'd0);
  // nibble mode sends the low nibble in the first (high) slot
  assign hi_nib = cur_entry.nibble ? cur_entry.data[3:0] : cur_entry.data[7:4];
  assign last_step = cur_entry.nibble ? (step == 3'd3) : (step == 3'd6);

  always_comb begin
    case (step)
      3'd0:    cur_byte_next = cur_byte | e_mask;
      3'd1:    cur_byte_next = cur_byte | lcdq_pkg::place_nibble(hi_nib, db_pos);
      3'd2:    cur_byte_next = cur_byte & ~e_mask;
      3'd3:    cur_byte_next = cur_byte | e_mask;
      3'd4:    cur_byte_next = (cur_byte & ~db_mask) |
                               lcdq_pkg::place_nibble(cur_entry.data[3:0], db_pos);
      3'd5:    cur_byte_next = cur_byte & ~e_mask;
      default: cur_byte_next = cur_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
      rs_pos       <= 3'd0;
      en_pos       <= 3'd2;
      bl_pos       <= 3'd3;
      db_pos       <= {3'd7, 3'd6, 3'd5, 3'd4};
    end else if (cfg_we) begin
      case (cfg_index)
        lcdq_pkg::REG_BACKLIGHT_ON:  backlight_on <= cfg_data[0];
        lcdq_pkg::REG_RS_POS:        rs_pos       <= cfg_data;
        lcdq_pkg::REG_ENABLE_POS:    en_pos       <= cfg_data;
        lcdq_pkg::REG_BACKLIGHT_POS: bl_pos       <= cfg_data;
        lcdq_pkg::REG_DB4_POS:       db_pos[0]    <= cfg_data;
        lcdq_pkg::REG_DB5_POS:       db_pos[1]    <= cfg_data;
        lcdq_pkg::REG_DB6_POS:       db_pos[2]    <= cfg_data;
        lcdq_pkg::REG_DB7_POS:       db_pos[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_index  <= '0;
      read_index   <= '0;
      wait_counter <= '0;
      res_valid    <= 1'b0;
      step         <= '0;
    end else begin
      res_valid <= res_load || (res_valid && !result.ready);
      unique case (state)
        ST_IDLE: begin
          if (is_push) begin
            if (!ring_full) write_index <= write_index_next;
            res_data.res_kind      <= lcdq_pkg::KIND_STATUS;
            res_data.push_accepted <= !ring_full;
            res_data.bus_byte      <= '0;
            res_data.last_byte     <= 1'b0;
          end else if (is_tick) begin
            if (wait_counter != '0) begin
              wait_counter <= wait_counter - 1'b1;
            end else if (do_pop) begin
              read_index <= read_index_next;
              state      <= ST_READ;
            end
          end
        end
        ST_READ: begin
          cur_entry    <= rd_entry;
          wait_counter <= rd_entry.delay;
          cur_byte     <= first_byte;
          step         <= '0;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            res_data.res_kind      <= lcdq_pkg::KIND_BYTE;
            res_data.push_accepted <= 1'b0;
            res_data.bus_byte      <= cur_byte;
            res_data.last_byte     <= last_step;
            cur_byte               <= cur_byte_next;
            step                   <= step + 1'b1;
            if (last_step) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_data;

  a_wait_dec: assert property (@(posedge clk) disable iff (rst)
    is_tick && (wait_counter != '0) |=> wait_counter == $past(wait_counter) - 6'd1)
    else $error("wait counter did not count down on tick");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && (res_data.res_kind == lcdq_pkg::KIND_STATUS)
      |-> (res_data.bus_byte == '0) && !res_data.last_byte)
    else $error("status result carries byte fields");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> $past(read_index) != $past(write_index))
    else $error("pop from empty ring");

  a_push_advance: assert property (@(posedge clk) disable iff (rst)
    is_push && !ring_full |=> write_index != $past(write_index))
    else $error("accepted push did not advance write index");

  a_emit_no_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free && last_step |=> result.valid && res_data.last_byte)
    else $error("final byte not presented");
endmodule

>>> sv/lcdq_ram.sv
// ----------------------------------------------------------------------------
// lcdq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lcdq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
